@@ hw/rtl/stps_pkg.sv @@
package stps_pkg;

  // fixed field widths
  localparam int unsigned IdxW      = 11;
  localparam int unsigned ValW      = 32;
  localparam int unsigned LeavesDef = 1024;

  // stream packing
  localparam int unsigned FirstLsb = 0;
  localparam int unsigned LastLsb  = FirstLsb + IdxW;
  localparam int unsigned AddLsb   = LastLsb + IdxW;
  localparam int unsigned STdataW  = ((AddLsb + ValW + 7) / 8) * 8;
  localparam int unsigned MTdataW  = ((ValW + 7) / 8) * 8;

  // command codes carried in tuser
  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_SUM = 1'b1;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLEAR,
    OP_LOAD,
    OP_RD_A,
    OP_RD_B,
    OP_ADD_WR,
    OP_ADD_UP,
    OP_SIB_A,
    OP_SIB_B,
    OP_DRAIN,
    OP_EMIT,
    OP_EMIT_ERR
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_ctl_t;

  typedef struct packed {
    logic clr_done;  // clearing pass at last word
    logic add_ok;    // live input: add index in range
    logic sum_ok;    // live input: sum range valid
    logic a_eq_b;    // both range ends on one leaf
    logic loop_go;   // range walk continues at this level
    logic add_top;   // parent of current node is the root
    logic out_free;  // result register can take a beat
  } dp_stat_t;

endpackage

@@ hw/rtl/segment_tree_point_add_range_sum.sv @@
// channel  | direction | signals                         | contents
// ---------+-----------+---------------------------------+-------------------------------------
// s_axis   | in        | tvalid/tready/tdata/tuser       | tuser: cmd (0 add, 1 sum)
//          |           |                                 | tdata: first_index, last_index, add_value
// m_axis   | out       | tvalid/tready/tdata/tuser       | tdata: range_sum, tuser: range_error
//
// the length of a beat is set by the tree walk on the single-port-read ram, one word read
// per level and side for sums, one read and one write per level for adds; a sum beat can
// also wait on output back-pressure
// after reset a clearing pass writes zero to all 2*Leaves words (2048 at the default),
// one a cycle, with s_axis_tready_o held low
// one beat in flight at a time; a finished sum sits in the output register while
// the next beat is taken, an add beat produces no output beat
module segment_tree_point_add_range_sum #(
  parameter int unsigned Leaves = stps_pkg::LeavesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input stream
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [stps_pkg::STdataW-1:0] s_axis_tdata_i,  // first_index, last_index, add_value
  input  logic                         s_axis_tuser_i,  // cmd
  // result stream
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [stps_pkg::MTdataW-1:0] m_axis_tdata_o,  // range_sum
  output logic                         m_axis_tuser_o   // range_error
);
  import stps_pkg::*;

  dp_ctl_t              dp_ctl;
  dp_stat_t             dp_stat;
  logic [IdxW-1:0]      first_index, last_index;
  logic signed [ValW-1:0] add_value, range_sum;

  // unpack the input beat
  assign first_index = s_axis_tdata_i[FirstLsb +: IdxW];
  assign last_index  = s_axis_tdata_i[LastLsb +: IdxW];
  assign add_value   = s_axis_tdata_i[AddLsb +: ValW];

  // sequencer for clear, add walk and range walk
  stps_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .cmd_i     (s_axis_tuser_i),
    .stat_i    (dp_stat),
    .ctl_o     (dp_ctl)
  );

  // tree memory, node pointers, accumulator and result register
  stps_datapath #(
    .Leaves(Leaves)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (dp_ctl),
    .stat_o       (dp_stat),
    .first_index_i(first_index),
    .last_index_i (last_index),
    .add_value_i  (add_value),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .range_sum_o  (range_sum),
    .range_error_o(m_axis_tuser_o)
  );

  assign m_axis_tdata_o = MTdataW'(range_sum);

endmodule

@@ hw/rtl/stps_ram.sv @@
module stps_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

@@ hw/rtl/stps_datapath.sv @@
module stps_datapath #(
  parameter int unsigned Leaves = stps_pkg::LeavesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  stps_pkg::dp_ctl_t             ctl_i,
  output stps_pkg::dp_stat_t            stat_o,
  input  logic [stps_pkg::IdxW-1:0]     first_index_i,
  input  logic [stps_pkg::IdxW-1:0]     last_index_i,
  input  logic signed [stps_pkg::ValW-1:0] add_value_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic signed [stps_pkg::ValW-1:0] range_sum_o,
  output logic                          range_error_o
);
  import stps_pkg::*;

  localparam int unsigned Depth = 2 * Leaves;
  localparam int unsigned NodeW = $clog2(Depth);

  logic [NodeW-1:0] node_a_q, node_a_d, node_b_q, node_b_d;
  logic [NodeW-1:0] clr_q, clr_d;
  logic [ValW-1:0]  amt_q, amt_d;
  logic [ValW-1:0]  acc_q, acc_d;
  logic             pend_q, pend_d;
  logic             out_valid_q, out_valid_d;
  logic [ValW-1:0]  out_sum_q, out_sum_d;
  logic             out_err_q, out_err_d;

  logic             wr_en;
  logic [NodeW-1:0] wr_addr, rd_addr;
  logic [ValW-1:0]  wr_data, rd_data;
  logic [ValW-1:0]  acc_in, leaf_new, node_new;
  logic [NodeW-1:0] leaf_a, leaf_b, parent_a;

  stps_ram #(
    .Width(ValW),
    .Depth(Depth)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  assign leaf_a   = NodeW'(32'(Leaves) + 32'(first_index_i) - 32'd1);
  assign leaf_b   = NodeW'(32'(Leaves) + 32'(last_index_i) - 32'd1);
  assign parent_a = {1'b0, node_a_q[NodeW-1:1]};
  assign acc_in   = acc_q + (pend_q ? rd_data : '0);
  assign leaf_new = rd_data + amt_q;
  assign node_new = acc_q + rd_data;

  always_comb begin
    stat_o.clr_done = &clr_q;
    stat_o.add_ok   = (first_index_i != '0) && (32'(first_index_i) <= 32'(Leaves));
    stat_o.sum_ok   = (first_index_i != '0) && (first_index_i <= last_index_i)
                      && (32'(last_index_i) <= 32'(Leaves));
    stat_o.a_eq_b   = (node_a_q == node_b_q);
    stat_o.loop_go  = ((node_a_q ^ node_b_q) != NodeW'(1)) && (node_a_q > NodeW'(1));
    stat_o.add_top  = (node_a_q[NodeW-1:1] == (NodeW-1)'(1));
    stat_o.out_free = !out_valid_q || out_ready_i;
  end

  always_comb begin
    node_a_d    = node_a_q;
    node_b_d    = node_b_q;
    clr_d       = clr_q;
    amt_d       = amt_q;
    acc_d       = acc_q;
    pend_d      = pend_q;
    out_sum_d   = out_sum_q;
    out_err_d   = out_err_q;
    out_valid_d = out_valid_q && !out_ready_i;
    wr_en       = 1'b0;
    wr_addr     = node_a_q;
    wr_data     = node_new;
    rd_addr     = node_a_q;
    unique case (ctl_i.op)
      OP_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
        clr_d   = clr_q + NodeW'(1);
      end
      OP_LOAD: begin
        node_a_d = leaf_a;
        node_b_d = leaf_b;
        amt_d    = add_value_i;
        acc_d    = '0;
        pend_d   = 1'b0;
      end
      OP_RD_A: begin
        rd_addr = node_a_q;
        acc_d   = acc_in;
        pend_d  = 1'b1;
      end
      OP_RD_B: begin
        rd_addr = node_b_q;
        acc_d   = acc_in;
        pend_d  = 1'b1;
      end
      OP_ADD_WR: begin
        // leaf updated, sibling fetched for the first parent
        wr_en   = 1'b1;
        wr_addr = node_a_q;
        wr_data = leaf_new;
        acc_d   = leaf_new;
        rd_addr = node_a_q ^ NodeW'(1);
        pend_d  = 1'b0;
      end
      OP_ADD_UP: begin
        wr_en    = 1'b1;
        wr_addr  = parent_a;
        wr_data  = node_new;
        acc_d    = node_new;
        node_a_d = parent_a;
        rd_addr  = parent_a ^ NodeW'(1);
      end
      OP_SIB_A: begin
        rd_addr = node_a_q ^ NodeW'(1);
        acc_d   = acc_in;
        pend_d  = !node_a_q[0];
      end
      OP_SIB_B: begin
        rd_addr  = node_b_q ^ NodeW'(1);
        acc_d    = acc_in;
        pend_d   = node_b_q[0];
        node_a_d = parent_a;
        node_b_d = {1'b0, node_b_q[NodeW-1:1]};
      end
      OP_DRAIN: begin
        acc_d  = acc_in;
        pend_d = 1'b0;
      end
      OP_EMIT: begin
        out_valid_d = 1'b1;
        out_sum_d   = acc_in;
        out_err_d   = 1'b0;
        pend_d      = 1'b0;
      end
      OP_EMIT_ERR: begin
        out_valid_d = 1'b1;
        out_sum_d   = '0;
        out_err_d   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clr_q       <= clr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_a_q  <= node_a_d;
    node_b_q  <= node_b_d;
    amt_q     <= amt_d;
    acc_q     <= acc_d;
    out_sum_q <= out_sum_d;
    out_err_q <= out_err_d;
  end

  assign out_valid_o   = out_valid_q;
  assign range_sum_o   = out_sum_q;
  assign range_error_o = out_err_q;

endmodule

@@ hw/rtl/stps_ctrl.sv @@
module stps_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  input  stps_pkg::dp_stat_t stat_i,
  output stps_pkg::dp_ctl_t  ctl_o
);
  import stps_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_ADD_UP,
    ST_SUM_RD_A,
    ST_SUM_RD_B,
    ST_SIB_A,
    ST_SIB_B,
    ST_DRAIN,
    ST_EMIT,
    ST_ERR
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    ctl_o.op   = OP_NOP;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        ctl_o.op = OP_CLEAR;
        if (stat_i.clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.op = OP_LOAD;
          if (cmd_i == CMD_ADD) begin
            state_d = stat_i.add_ok ? ST_ADD_RD : ST_IDLE;
          end else begin
            state_d = stat_i.sum_ok ? ST_SUM_RD_A : ST_ERR;
          end
        end
      end
      ST_ADD_RD: begin
        ctl_o.op = OP_RD_A;
        state_d  = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        ctl_o.op = OP_ADD_WR;
        state_d  = ST_ADD_UP;
      end
      ST_ADD_UP: begin
        ctl_o.op = OP_ADD_UP;
        if (stat_i.add_top) begin
          state_d = ST_IDLE;
        end
      end
      ST_SUM_RD_A: begin
        ctl_o.op = OP_RD_A;
        state_d  = stat_i.a_eq_b ? ST_DRAIN : ST_SUM_RD_B;
      end
      ST_SUM_RD_B: begin
        ctl_o.op = OP_RD_B;
        state_d  = ST_SIB_A;
      end
      ST_SIB_A: begin
        if (stat_i.loop_go) begin
          ctl_o.op = OP_SIB_A;
          state_d  = ST_SIB_B;
        end else begin
          ctl_o.op = OP_DRAIN;
          state_d  = ST_EMIT;
        end
      end
      ST_SIB_B: begin
        ctl_o.op = OP_SIB_B;
        state_d  = ST_SIB_A;
      end
      ST_DRAIN: begin
        ctl_o.op = OP_DRAIN;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          ctl_o.op = OP_EMIT;
          state_d  = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (stat_i.out_free) begin
          ctl_o.op = OP_EMIT_ERR;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
